// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Types and constants for the HSV to RGB pixel pipeline.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam logic [8:0] HUE_MAX = 9'd360;
  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  // floor(x / D) as (x * M) >> K, exact over the whole input range
  localparam logic [15:0] FULL_RECIP = 16'd41944;      // D = 100,    x < 2^15
  localparam int          FULL_SHIFT = 22;
  localparam logic [22:0] LOW_RECIP  = 23'd6871948;    // D = 10000,  x < 2^22
  localparam int          LOW_SHIFT  = 36;
  localparam logic [28:0] MID_RECIP  = 29'd469124962;  // D = 600000, x < 2^28
  localparam int          MID_SHIFT  = 48;

  // 60 degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // after the prepare stages
  typedef struct packed {
    sector_t     sector;
    logic [6:0]  nsat;    // 100 - s
    logic [12:0] term;    // 60*(100-s) + s*(60-d)
    logic [14:0] fv;      // 255 * v
  } prep_t;

  // after the scale stages
  typedef struct packed {
    sector_t    sector;
    logic [7:0] full;
    logic [7:0] mid;
    logic [7:0] low;
  } level_t;

endpackage

// ===== src/hsv_to_rgb_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// HSV pixel (degrees, percent, percent) to 8-bit RGB, five-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and carries each result through the registers
// of stages A to D and the output stage. Out-of-range inputs are clipped
// (hue to 360, saturation and brightness to 100). Two stages clip and form
// the narrow terms, two run the multipliers (numerators, then the reciprocal
// products for the exact floor divisions), the last routes levels to channels.
// Every stage holds its item when the next one is full, so back-pressure on
// the output costs no data; throughput stays at one pixel a cycle while
// out_ready is high.
`include "assert_macros.svh"

module hsv_to_rgb_pixel_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] in_hue,
  input  logic [6:0] in_saturation,
  input  logic [6:0] in_brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic            prep_valid, prep_ready;
  hrp_pkg::prep_t  prep_data;
  logic            lvl_valid, lvl_ready;
  hrp_pkg::level_t lvl_data;
  logic            lvl_ordered;

  hrp_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .dn_valid      (prep_valid),
    .dn_ready      (prep_ready),
    .dn_data       (prep_data)
  );

  hrp_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .up_data  (prep_data),
    .dn_valid (lvl_valid),
    .dn_ready (lvl_ready),
    .dn_data  (lvl_data)
  );

  hrp_mux u_mux (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (lvl_valid),
    .up_ready  (lvl_ready),
    .up_data   (lvl_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  assign lvl_ordered = (lvl_data.low <= lvl_data.mid) && (lvl_data.mid <= lvl_data.full);

  // a ready sink must open the whole pipe
  `ASSERT_ON(a_ready_chain, clk, rst_n, out_ready |-> in_ready, "pipe blocked with sink ready")
  // levels are ordered low <= mid <= full whatever the pixel
  `ASSERT_ON(a_level_order, clk, rst_n, lvl_valid |-> lvl_ordered, "level ordering broken")
  // reset empties the output stage
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

// ===== src/hrp_prep.sv =====
// ----------------------------------------------------------------------------
// hrp_prep
// Two stages: clip inputs, find sector and hue distance; then form the
// narrow terms that feed the scale multipliers.
// ----------------------------------------------------------------------------
module hrp_prep (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [8:0]    in_hue,
  input  logic [6:0]    in_saturation,
  input  logic [6:0]    in_brightness,
  output logic          dn_valid,
  input  logic          dn_ready,
  output hrp_pkg::prep_t dn_data
);

  // stage A
  logic             va_r;
  hrp_pkg::sector_t sec_a_r, sec_a_nxt;
  logic [6:0]       s_a_r, s_a_nxt;
  logic [6:0]       v_a_r, v_a_nxt;
  logic [5:0]       d_a_r, d_a_nxt;
  logic             rdy_a;

  // stage B
  logic           vb_r;
  hrp_pkg::prep_t pb_r, pb_nxt;
  logic           rdy_b;

  logic [8:0] h;
  logic [6:0] hm;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    h       = (in_hue > hrp_pkg::HUE_MAX) ? hrp_pkg::HUE_MAX : in_hue;
    s_a_nxt = (in_saturation > hrp_pkg::PCT_MAX) ? hrp_pkg::PCT_MAX : in_saturation;
    v_a_nxt = (in_brightness > hrp_pkg::PCT_MAX) ? hrp_pkg::PCT_MAX : in_brightness;
    // hue 360 lands in the last sector
    if (h >= 9'd300) begin
      sec_a_nxt = hrp_pkg::SEC_MAG_RED;
    end else if (h >= 9'd240) begin
      sec_a_nxt = hrp_pkg::SEC_BLU_MAG;
    end else if (h >= 9'd180) begin
      sec_a_nxt = hrp_pkg::SEC_CYN_BLU;
    end else if (h >= 9'd120) begin
      sec_a_nxt = hrp_pkg::SEC_GRN_CYN;
    end else if (h >= 9'd60) begin
      sec_a_nxt = hrp_pkg::SEC_YEL_GRN;
    end else begin
      sec_a_nxt = hrp_pkg::SEC_RED_YEL;
    end
    // hue mod 120 (hue 360 gives 120)
    if (h >= 9'd240) begin
      hm = 7'(h - 9'd240);
    end else if (h >= 9'd120) begin
      hm = 7'(h - 9'd120);
    end else begin
      hm = h[6:0];
    end
    d_a_nxt = (hm >= 7'd60) ? 6'(hm - 7'd60) : 6'(7'd60 - hm);
  end

  always_comb begin
    pb_nxt.sector = sec_a_r;
    pb_nxt.nsat   = hrp_pkg::PCT_MAX - s_a_r;
    pb_nxt.term   = 13'(pb_nxt.nsat * 6'd60) + 13'(s_a_r * (6'd60 - d_a_r));
    pb_nxt.fv     = 15'(v_a_r * hrp_pkg::LEVEL_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      sec_a_r <= sec_a_nxt;
      s_a_r   <= s_a_nxt;
      v_a_r   <= v_a_nxt;
      d_a_r   <= d_a_nxt;
    end
    if (rdy_b && va_r) begin
      pb_r <= pb_nxt;
    end
  end

  assign dn_valid = vb_r;
  assign dn_data  = pb_r;

endmodule

// ===== src/hrp_scale.sv =====
// ----------------------------------------------------------------------------
// hrp_scale
// Two multiply stages: the level numerators, then the reciprocal products
// that stand in for the divisions by 100, 10000 and 600000.
// ----------------------------------------------------------------------------
module hrp_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  hrp_pkg::prep_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output hrp_pkg::level_t dn_data
);

  // stage C: numerators
  logic             vc_r;
  hrp_pkg::sector_t sec_c_r;
  logic [21:0]      low_num_r, low_num_nxt;
  logic [27:0]      mid_num_r, mid_num_nxt;
  logic [30:0]      full_prod_r, full_prod_nxt;
  logic             rdy_c;

  // stage D: quotients
  logic            vd_r;
  hrp_pkg::level_t ld_r, ld_nxt;
  logic [44:0]     low_prod;
  logic [56:0]     mid_prod;
  logic            rdy_d;

  assign rdy_d    = !vd_r || dn_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign up_ready = rdy_c;

  always_comb begin
    low_num_nxt   = 22'(up_data.fv * up_data.nsat);
    mid_num_nxt   = 28'(up_data.fv * up_data.term);
    full_prod_nxt = 31'(up_data.fv * hrp_pkg::FULL_RECIP);
  end

  always_comb begin
    low_prod      = 45'(low_num_r * hrp_pkg::LOW_RECIP);
    mid_prod      = 57'(mid_num_r * hrp_pkg::MID_RECIP);
    ld_nxt.sector = sec_c_r;
    ld_nxt.full   = full_prod_r[hrp_pkg::FULL_SHIFT +: 8];
    ld_nxt.low    = low_prod[hrp_pkg::LOW_SHIFT +: 8];
    ld_nxt.mid    = mid_prod[hrp_pkg::MID_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_c) vc_r <= up_valid;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && up_valid) begin
      sec_c_r     <= up_data.sector;
      low_num_r   <= low_num_nxt;
      mid_num_r   <= mid_num_nxt;
      full_prod_r <= full_prod_nxt;
    end
    if (rdy_d && vc_r) begin
      ld_r <= ld_nxt;
    end
  end

  assign dn_valid = vd_r;
  assign dn_data  = ld_r;

endmodule

// ===== src/hrp_mux.sv =====
// ----------------------------------------------------------------------------
// hrp_mux
// Output stage: routes full, mid and low onto red, green and blue by sector.
// ----------------------------------------------------------------------------
module hrp_mux (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  hrp_pkg::level_t up_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue
);

  logic       vo_r;
  logic [7:0] red_r, red_nxt;
  logic [7:0] green_r, green_nxt;
  logic [7:0] blue_r, blue_nxt;

  assign up_ready = !vo_r || out_ready;

  always_comb begin
    case (up_data.sector)
      hrp_pkg::SEC_RED_YEL: begin
        red_nxt = up_data.full; green_nxt = up_data.mid;  blue_nxt = up_data.low;
      end
      hrp_pkg::SEC_YEL_GRN: begin
        red_nxt = up_data.mid;  green_nxt = up_data.full; blue_nxt = up_data.low;
      end
      hrp_pkg::SEC_GRN_CYN: begin
        red_nxt = up_data.low;  green_nxt = up_data.full; blue_nxt = up_data.mid;
      end
      hrp_pkg::SEC_CYN_BLU: begin
        red_nxt = up_data.low;  green_nxt = up_data.mid;  blue_nxt = up_data.full;
      end
      hrp_pkg::SEC_BLU_MAG: begin
        red_nxt = up_data.mid;  green_nxt = up_data.low;  blue_nxt = up_data.full;
      end
      default: begin
        red_nxt = up_data.full; green_nxt = up_data.low;  blue_nxt = up_data.mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (up_ready) begin
      vo_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule
